>>> rtl/screen_hot_corner_detector_core_assert.svh
// Assertion macros for the hot corner detector core.
// No dependencies; included inside module bodies.
`ifndef SCREEN_HOT_CORNER_DETECTOR_CORE_ASSERT_SVH
`define SCREEN_HOT_CORNER_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SHCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shcd assertion failed");

// next-cycle implication, disabled during reset
`define SHCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shcd assertion failed");

`endif

>>> rtl/shcd_pkg.sv
// Types, constants and codes for the hot corner detector.
// No dependencies.
package shcd_pkg;

    localparam int MAX_MONITORS = 8;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_W        = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;
    localparam int CNT_W        = $clog2(MAX_MONITORS + 1);
    localparam int SLOT_W       = 3;
    localparam int TOL_W        = 8;
    localparam int MCNT_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_COUNT = 2'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COORD_WIDTH:0]   t_wide;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_rect;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        t_coord            rect_left;
        t_coord            rect_top;
        t_coord            rect_right;
        t_coord            rect_bottom;
        t_coord            cursor_x;
        t_coord            cursor_y;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [2:0] hit_monitor;
        logic [1:0] hit_corner;
    } t_rsp;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_rect            wdata;
        logic [IDX_W-1:0] raddr;
    } t_tbl_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_LD_A,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

endpackage

>>> rtl/screen_hot_corner_detector_core.sv
// Hot corner detector core. A load writes one table slot. A query tests monitors in turn,
// reading each from the table; one that holds the cursor gets a full neighbor scan and
// an evaluation, one that does not is rejected. Queries use the single table read port.
// Busy drops in the cycle after the result, so no new request is taken before then.
// Sync active-low reset: tolerance 1, monitor_count 0, table reads empty. Results are a
// one-cycle strobe; the receiver cannot stall. Depends on shcd_pkg, shcd_table, assert svh.
module screen_hot_corner_detector_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  shcd_pkg::t_req                       i_req,
    output logic                                 o_done,
    output shcd_pkg::t_rsp                       o_rsp,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [shcd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [shcd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import shcd_pkg::*;
    `include "screen_hot_corner_detector_core_assert.svh"

    function automatic logic rect_valid(input t_rect r);
        return (r.left < r.right) && (r.top < r.bottom);
    endfunction

    t_state             r_state, n_state;
    logic [TOL_W-1:0]   r_tol;
    logic [MCNT_W-1:0]  r_count;
    logic [CNT_W-1:0]   r_qcount, n_qcount;
    logic [TOL_W-1:0]   r_qtol, n_qtol;
    t_coord             r_cx, n_cx, r_cy, n_cy;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j;
    t_rect              r_a, n_a;
    logic [3:0]         r_near, n_near;   // {nb, nt, nr, nl}
    logic [3:0]         r_sides, n_sides; // {bottom, top, right, left}
    t_rsp               r_rsp, n_rsp;

    t_tbl_req           tbl_req;
    t_rect              rd;

    logic               i_last, j_last, contains, ov_v, ov_h;
    t_wide              left_tol, right_tol, top_tol, bottom_tol;
    logic [1:0]         corner;
    logic               corner_hit;

    shcd_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (rd)
    );

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_W'(1);
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOLERANCE:     r_tol   <= i_cfg_data[TOL_W-1:0];
                CFG_MONITOR_COUNT: r_count <= i_cfg_data[MCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qcount <= n_qcount;
        r_qtol   <= n_qtol;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_i      <= n_i;
        r_j      <= n_j;
        r_a      <= n_a;
        r_near   <= n_near;
        r_sides  <= n_sides;
        r_rsp    <= n_rsp;
    end

    // edge +/- tolerance one bit wider so nothing wraps near the limits
    always_comb begin
        left_tol   = t_wide'(rd.left)   + t_wide'(r_qtol);
        top_tol    = t_wide'(rd.top)    + t_wide'(r_qtol);
        right_tol  = t_wide'(rd.right)  - t_wide'(r_qtol);
        bottom_tol = t_wide'(rd.bottom) - t_wide'(r_qtol);
        contains   = rect_valid(rd) && (r_cx >= rd.left) && (r_cx < rd.right)
                     && (r_cy >= rd.top) && (r_cy < rd.bottom);
        ov_v       = (r_a.top < rd.bottom) && (rd.top < r_a.bottom);
        ov_h       = (r_a.left < rd.right) && (rd.left < r_a.right);
        i_last     = (CNT_W'(r_i) + CNT_W'(1)) >= r_qcount;
        j_last     = (CNT_W'(r_j) + CNT_W'(1)) >= r_qcount;
    end

    always_comb begin
        corner_hit = 1'b1;
        if (r_near[0] && r_near[2] && r_sides[0] && r_sides[2]) begin
            corner = CORNER_TL;
        end else if (r_near[1] && r_near[2] && r_sides[1] && r_sides[2]) begin
            corner = CORNER_TR;
        end else if (r_near[0] && r_near[3] && r_sides[0] && r_sides[3]) begin
            corner = CORNER_BL;
        end else if (r_near[1] && r_near[3] && r_sides[1] && r_sides[3]) begin
            corner = CORNER_BR;
        end else begin
            corner     = CORNER_TL;
            corner_hit = 1'b0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_qcount = r_qcount;
        n_qtol   = r_qtol;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_i      = r_i;
        n_j      = r_j;
        n_a      = r_a;
        n_near   = r_near;
        n_sides  = r_sides;
        n_rsp    = r_rsp;
        tbl_req  = '{we: 1'b0, waddr: IDX_W'(i_req.slot), wdata: '0, raddr: r_i};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rsp = '0;
                    if (i_req.kind == KIND_LOAD) begin
                        tbl_req.we    = (int'(i_req.slot) < MAX_MONITORS);
                        tbl_req.wdata = '{left: i_req.rect_left, top: i_req.rect_top,
                                          right: i_req.rect_right,
                                          bottom: i_req.rect_bottom};
                        n_state = S_DONE;
                    end else begin
                        n_qcount = (int'(r_count) > MAX_MONITORS) ?
                                   CNT_W'(MAX_MONITORS) : CNT_W'(r_count);
                        n_qtol   = (r_tol == '0) ? TOL_W'(1) : r_tol;
                        n_cx     = i_req.cursor_x;
                        n_cy     = i_req.cursor_y;
                        n_i      = '0;
                        n_state  = (r_count == '0) ? S_DONE : S_RD_A;
                    end
                end
            end
            S_RD_A: begin
                tbl_req.raddr = r_i;
                n_state       = S_LD_A;
            end
            S_LD_A: begin
                n_a    = rd;
                n_near = {(t_wide'(r_cy) >= bottom_tol), (t_wide'(r_cy) < top_tol),
                          (t_wide'(r_cx) >= right_tol),  (t_wide'(r_cx) < left_tol)};
                if (contains) begin
                    tbl_req.raddr = '0;
                    n_j           = '0;
                    n_sides       = 4'hF;
                    n_state       = S_SCAN;
                end else if (i_last) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_RD_A;
                end
            end
            S_SCAN: begin
                // rd holds neighbor r_j
                if ((r_j != r_i) && rect_valid(rd)) begin
                    if (ov_v && (rd.right == r_a.left))  n_sides[0] = 1'b0;
                    if (ov_v && (rd.left == r_a.right))  n_sides[1] = 1'b0;
                    if (ov_h && (rd.bottom == r_a.top))  n_sides[2] = 1'b0;
                    if (ov_h && (rd.top == r_a.bottom))  n_sides[3] = 1'b0;
                end
                if (j_last) begin
                    n_state = S_EVAL;
                end else begin
                    tbl_req.raddr = r_j + IDX_W'(1);
                    n_j           = r_j + IDX_W'(1);
                end
            end
            S_EVAL: begin
                if (corner_hit) begin
                    n_rsp   = '{hit: 1'b1, hit_monitor: 3'(r_i), hit_corner: corner};
                    n_state = S_DONE;
                end else if (i_last) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_RD_A;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `SHCD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `SHCD_ASSERT_NXT(a_done_strobe, i_clk, i_rst_n, o_done, !o_done && !o_busy)
    `SHCD_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_done && !o_rsp.hit,
                     (o_rsp.hit_monitor == 3'd0) && (o_rsp.hit_corner == CORNER_TL))
    `SHCD_ASSERT_IMP(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN,
                     (CNT_W'(r_j) < r_qcount) && (CNT_W'(r_i) < r_qcount))

endmodule

>>> rtl/shcd_table.sv
// Monitor rectangle table: one write port, one registered read port.
// Depends on shcd_pkg. Per-entry valid bits make unwritten entries read as empty.
module shcd_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shcd_pkg::t_tbl_req i_req,
    output shcd_pkg::t_rect   o_rd_data
);
    import shcd_pkg::*;

    t_rect                  r_mem [MAX_MONITORS];
    logic [MAX_MONITORS-1:0] r_vld;
    t_rect                  r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    // never-written entries read as all zero, an empty rectangle
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
